// File: hdl/gga_pkg.sv
package gga_pkg;

    // result kinds
    typedef enum logic [1:0] {
        EV_FIELD    = 2'd0,
        EV_SENTENCE = 2'd1,
        EV_ERROR    = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        CAUSE_NONE        = 3'd0,
        CAUSE_BAD_LETTER  = 3'd1,
        CAUSE_WRONG_TAG   = 3'd2,
        CAUSE_MISPLACED   = 3'd3,
        CAUSE_EARLY_END   = 3'd4,
        CAUSE_TOO_LONG    = 3'd5,
        CAUSE_CHKSUM_COMMA = 3'd6
    } cause_t;

    localparam int unsigned POS_W = 5;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_IDLE     = 5'd0;
    localparam pos_t POS_TAG      = 5'd1;
    localparam pos_t POS_LAT_DIR  = 5'd4;
    localparam pos_t POS_LON_DIR  = 5'd6;
    localparam pos_t POS_ALT_UNIT = 5'd11;
    localparam pos_t POS_SEP_UNIT = 5'd13;
    localparam pos_t POS_STATION  = 5'd15;
    localparam pos_t POS_CHECKSUM = 5'd16;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam int unsigned TAG_LEN = 5;

    // expected sentence tag, lower case
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h67;   // g
            3'd1:    ch = 8'h70;   // p
            3'd2:    ch = 8'h67;   // g
            3'd3:    ch = 8'h67;   // g
            3'd4:    ch = 8'h61;   // a
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    typedef struct packed {
        logic [31:0] value;
        logic        overflow;
    } acc_res_t;

endpackage

// File: hdl/gga_accum.sv
module gga_accum
    import gga_pkg::*;
(
    input  logic [31:0] acc,
    input  logic        hex_radix,
    input  logic [3:0]  digit,
    output acc_res_t    res
);

    logic [35:0] scaled;
    logic [36:0] sum;

    // times sixteen is a shift, times ten is eight plus two
    always_comb begin
        if (hex_radix) begin
            scaled = {acc, 4'b0000};
        end else begin
            scaled = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
        end
        sum = {1'b0, scaled} + {33'd0, digit};
        res.overflow = |sum[36:32];
        res.value    = res.overflow ? 32'hFFFF_FFFF : sum[31:0];
    end

endmodule

// File: hdl/gga_sentence_field_parser.sv
// GGA sentence field parser: takes one sentence byte per item on s_char_in and gives at
// most one result per byte: a completed field with its decimal mantissa, fraction digit
// count, sign and first character; the hex checksum at the line end; or a coded error,
// after which the parser waits for the next '$'. One byte is taken every cycle while the
// output is not stalled; each byte is registered in the input register, its result in the
// result register on m_valid. The cycle is bounded by the multiply-by-ten-or-sixteen
// accumulate with clamping on the 32-bit field value. A byte is held in the input register
// while a result waits on m_ready, so one byte is accepted even while the output is
// stalled. MAX_FIELD_LEN counted characters are allowed per field (8 to 63).
module gga_sentence_field_parser
    import gga_pkg::*;
#(
    parameter int unsigned MAX_FIELD_LEN = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [4:0]  m_field_index,
    output logic [31:0] m_magnitude,
    output logic        m_is_negative,
    output logic [4:0]  m_fraction_digits,
    output logic [7:0]  m_first_letter,
    output logic        m_saturated,
    output logic [2:0]  m_error_cause
);

    localparam int unsigned CNT_W = $clog2(MAX_FIELD_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELD_LEN);
    localparam logic [CNT_W-1:0] CNT_TAG = CNT_W'(TAG_LEN);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       advance;

    // parser state
    pos_t             pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      acc_reg, acc_next;
    logic [4:0]       frac_reg, frac_next;
    logic             dot_reg, dot_next;
    logic             minus_reg, minus_next;
    logic [7:0]       first_reg, first_next;
    logic             tag_ok_reg, tag_ok_next;
    logic             ovf_reg, ovf_next;

    // result register
    logic        out_valid_reg;
    event_t      ev_reg, ev_next;
    pos_t        idx_reg, idx_next;
    logic [31:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [4:0]  fd_reg, fd_next;
    logic [7:0]  fl_reg, fl_next;
    logic        sat_reg, sat_next;
    cause_t      cause_reg, cause_next;
    logic        emit;

    logic [7:0] c;
    logic       is_digit, is_lower, is_hex, counted, letter_field;
    logic [3:0] digit;
    acc_res_t   acc_res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_in;
        end
    end

    // character classes
    always_comb begin
        c = in_char_reg;
        if (c inside {["A":"Z"]}) begin
            c = c + CASE_OFFSET;
        end
        is_digit = c inside {["0":"9"]};
        is_lower = c inside {["a":"z"]};
        is_hex   = is_digit || (c inside {["a":"f"]});
        counted  = is_digit || is_lower || c == CH_MINUS || c == CH_DOT;
        letter_field = pos_reg == POS_TAG || pos_reg == POS_LAT_DIR ||
                       pos_reg == POS_LON_DIR || pos_reg == POS_ALT_UNIT ||
                       pos_reg == POS_SEP_UNIT;
        if (is_digit) begin
            digit = 4'(c - CH_ZERO);
        end else begin
            digit = 4'(c - CH_LOWER_A + 8'd10);
        end
    end

    gga_accum u_accum (
        .acc       (acc_reg),
        .hex_radix (pos_reg == POS_CHECKSUM),
        .digit     (digit),
        .res       (acc_res)
    );

    always_comb begin
        logic clear;
        logic err;
        logic val;
        event_t val_ev;
        cause_t err_cause;

        clear     = 1'b0;
        err       = 1'b0;
        val       = 1'b0;
        val_ev    = EV_FIELD;
        err_cause = CAUSE_NONE;

        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        frac_next   = frac_reg;
        dot_next    = dot_reg;
        minus_next  = minus_reg;
        first_next  = first_reg;
        tag_ok_next = tag_ok_reg;
        ovf_next    = ovf_reg;

        if (c == CH_DOLLAR) begin
            pos_next = POS_TAG;
            clear    = 1'b1;
        end else if (pos_reg == POS_IDLE || pos_reg > POS_CHECKSUM) begin
            pos_next = POS_IDLE;
        end else if (c == CH_COMMA) begin
            if (pos_reg == POS_CHECKSUM) begin
                err       = 1'b1;
                err_cause = CAUSE_CHKSUM_COMMA;
            end else if (pos_reg == POS_TAG && !(tag_ok_reg && cnt_reg == CNT_TAG)) begin
                err       = 1'b1;
                err_cause = CAUSE_WRONG_TAG;
            end else begin
                val      = 1'b1;
                pos_next = pos_reg + 5'd1;
                clear    = 1'b1;
            end
        end else if (c == CH_STAR) begin
            if (pos_reg != POS_STATION) begin
                err       = 1'b1;
                err_cause = CAUSE_MISPLACED;
            end else begin
                val      = 1'b1;
                pos_next = POS_CHECKSUM;
                clear    = 1'b1;
            end
        end else if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
            if (pos_reg != POS_CHECKSUM) begin
                err       = 1'b1;
                err_cause = CAUSE_EARLY_END;
            end else begin
                val      = 1'b1;
                val_ev   = EV_SENTENCE;
                pos_next = POS_IDLE;
                clear    = 1'b1;
            end
        end else if (counted) begin
            if ((pos_reg == POS_CHECKSUM && !is_hex) ||
                (pos_reg != POS_CHECKSUM && is_lower && !letter_field)) begin
                err       = 1'b1;
                err_cause = CAUSE_BAD_LETTER;
            end else if (cnt_reg >= CNT_MAX) begin
                err       = 1'b1;
                err_cause = CAUSE_TOO_LONG;
            end else begin
                if (cnt_reg == '0) begin
                    first_next = c;
                end
                if (pos_reg == POS_TAG) begin
                    if (cnt_reg >= CNT_TAG || tag_char(cnt_reg[2:0]) != c) begin
                        tag_ok_next = 1'b0;
                    end
                end
                if (pos_reg == POS_CHECKSUM || is_digit) begin
                    acc_next = acc_res.value;
                    if (acc_res.overflow) begin
                        ovf_next = 1'b1;
                    end
                    if (pos_reg != POS_CHECKSUM && dot_reg && frac_reg != 5'd31) begin
                        frac_next = frac_reg + 5'd1;
                    end
                end else if (c == CH_DOT) begin
                    dot_next = 1'b1;
                end else if (c == CH_MINUS && cnt_reg == '0) begin
                    minus_next = 1'b1;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (err) begin
            pos_next = POS_IDLE;
            clear    = 1'b1;
        end
        if (clear) begin
            cnt_next    = '0;
            acc_next    = '0;
            frac_next   = '0;
            dot_next    = 1'b0;
            minus_next  = 1'b0;
            first_next  = '0;
            tag_ok_next = 1'b1;
            ovf_next    = 1'b0;
        end

        emit       = err || val;
        idx_next   = pos_reg;
        ev_next    = err ? EV_ERROR : val_ev;
        cause_next = err_cause;
        mag_next   = err ? 32'd0 : acc_reg;
        neg_next   = !err && val_ev == EV_FIELD && minus_reg;
        fd_next    = (!err && val_ev == EV_FIELD) ? frac_reg : 5'd0;
        fl_next    = err ? 8'd0 : first_reg;
        sat_next   = !err && ovf_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_IDLE;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            frac_reg   <= '0;
            dot_reg    <= 1'b0;
            minus_reg  <= 1'b0;
            first_reg  <= '0;
            tag_ok_reg <= 1'b1;
            ovf_reg    <= 1'b0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            frac_reg   <= frac_next;
            dot_reg    <= dot_next;
            minus_reg  <= minus_next;
            first_reg  <= first_next;
            tag_ok_reg <= tag_ok_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            ev_reg    <= ev_next;
            idx_reg   <= idx_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            fd_reg    <= fd_next;
            fl_reg    <= fl_next;
            sat_reg   <= sat_next;
            cause_reg <= cause_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_res       = ev_reg;
    assign m_field_index     = idx_reg;
    assign m_magnitude       = mag_reg;
    assign m_is_negative     = neg_reg;
    assign m_fraction_digits = fd_reg;
    assign m_first_letter    = fl_reg;
    assign m_saturated       = sat_reg;
    assign m_error_cause     = cause_reg;

    a_error_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_ERROR |->
            m_magnitude == 32'd0 && !m_saturated && m_first_letter == 8'd0 &&
            !m_is_negative && m_fraction_digits == 5'd0)
        else $error("error item carries a payload");

    a_cause_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EV_ERROR |-> m_error_cause == CAUSE_NONE)
        else $error("cause set on a non-error item");

    a_sentence_at_checksum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_SENTENCE |->
            m_field_index == POS_CHECKSUM && !m_is_negative && m_fraction_digits == 5'd0)
        else $error("sentence item outside the checksum field");

    a_position_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_CHECKSUM)
        else $error("field position beyond the checksum field");

    a_field_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("field character count beyond the limit");

endmodule
